// ===== src/assert_macros.svh =====
// Assertion helpers for the deque store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== src/pds_pkg.sv =====
package pds_pkg;
	localparam int unsigned CapacityDefault  = 256;
	localparam int unsigned DataWidthDefault = 32;
	localparam int unsigned CmdW   = 4;
	localparam int unsigned PosW   = 9;
	localparam int unsigned ValueW = 32;
	localparam int unsigned CountW = 9;
	localparam int unsigned StatW  = 2;

	typedef enum logic [CmdW-1:0] {
		CMD_PUSH_FRONT = 4'd0,
		CMD_PUSH_BACK  = 4'd1,
		CMD_POP_FRONT  = 4'd2,
		CMD_POP_BACK   = 4'd3,
		CMD_PUSH_MID   = 4'd4,
		CMD_POP_MID    = 4'd5,
		CMD_INSERT     = 4'd6,
		CMD_ERASE      = 4'd7,
		CMD_READ       = 4'd8,
		CMD_REVERSE    = 4'd9,
		CMD_CLEAR      = 4'd10
	} cmd_t;

	typedef enum logic [StatW-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DECIDE,
		S_ALLOC,
		S_WALK,
		S_LINK,
		S_UNLINK,
		S_READ,
		S_REV,
		S_CLEAR,
		S_DONE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic latch;      // capture input word
		logic alloc_init; // start free-slot search
		logic alloc_step; // examine one slot
		logic walk_init;  // point cursor at head
		logic walk_step;  // follow one next link
		logic link;       // splice new node in (sequenced writes)
		logic unlink;     // splice cursor node out
		logic read;       // fetch element at cursor
		logic rev_init;
		logic rev_step;
		logic clr_init;
		logic clr_step;
		logic finish;     // load result register
		logic [StatW-1:0] status;
	} pds_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [CmdW-1:0] cmd;
		logic empty;
		logic full;
		logic short_list;
		logic range_err;
		logic alloc_hit;
		logic walk_done;
		logic seq_done;
		logic rev_done;
		logic clr_done;
	} pds_stat_t;
endpackage

// ===== src/pds_if.sv =====
interface pds_if #(parameter int unsigned W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/pds_ctrl.sv =====
module pds_ctrl import pds_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      out_busy,
	input  pds_stat_t st,
	output pds_cmd_t  cm
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cm       = '0;
		cm.status = ST_OK;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_INIT: begin
				cm.clr_step = 1'b1;
				if (st.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cm.latch = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				case (cmd_t'(st.cmd)) inside
					CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_PUSH_MID, CMD_INSERT: begin
						if (cmd_t'(st.cmd) == CMD_INSERT && st.empty) begin
							cm.status = ST_EMPTY; state_d = S_DONE;
						end else if (st.full) begin
							cm.status = ST_FULL; state_d = S_DONE;
						end else begin
							cm.alloc_init = 1'b1; state_d = S_ALLOC;
						end
					end
					CMD_POP_FRONT, CMD_POP_BACK, CMD_POP_MID, CMD_ERASE: begin
						if (st.empty) begin
							cm.status = ST_EMPTY; state_d = S_DONE;
						end else begin
							cm.walk_init = 1'b1; state_d = S_WALK;
						end
					end
					CMD_READ: begin
						if (st.range_err) begin
							cm.status = ST_RANGE; state_d = S_DONE;
						end else begin
							cm.walk_init = 1'b1; state_d = S_WALK;
						end
					end
					CMD_REVERSE: begin
						if (st.short_list) state_d = S_DONE;
						else begin
							cm.rev_init = 1'b1; state_d = S_REV;
						end
					end
					CMD_CLEAR: begin
						cm.clr_init = 1'b1; state_d = S_CLEAR;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_ALLOC: begin
				if (st.alloc_hit) begin
					cm.walk_init = 1'b1; state_d = S_WALK;
				end else cm.alloc_step = 1'b1;
			end
			S_WALK: begin
				if (st.walk_done) begin
					if (cmd_t'(st.cmd) == CMD_READ) state_d = S_READ;
					else if (st.cmd == CMD_POP_FRONT || st.cmd == CMD_POP_BACK ||
						st.cmd == CMD_POP_MID || st.cmd == CMD_ERASE) state_d = S_UNLINK;
					else state_d = S_LINK;
				end else cm.walk_step = 1'b1;
			end
			S_LINK: begin
				cm.link = 1'b1;
				if (st.seq_done) state_d = S_DONE;
			end
			S_UNLINK: begin
				cm.unlink = 1'b1;
				if (st.seq_done) state_d = S_DONE;
			end
			S_READ: begin
				cm.read = 1'b1;
				if (st.seq_done) state_d = S_DONE;
			end
			S_REV: begin
				cm.rev_step = 1'b1;
				if (st.rev_done) state_d = S_DONE;
			end
			S_CLEAR: begin
				cm.clr_step = 1'b1;
				if (st.clr_done) state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_busy) begin
					cm.finish = 1'b1; state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ===== src/pds_dp.sv =====
module pds_dp import pds_pkg::*; #(
	parameter int unsigned CAPACITY   = CapacityDefault,
	parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CmdW-1:0]   in_cmd,
	input  logic [PosW-1:0]   in_pos,
	input  logic [ValueW-1:0] in_value,
	input  pds_cmd_t          cm,
	input  logic [StatW-1:0]  st_code,
	output pds_stat_t         st,
	output logic [ValueW-1:0] res_value,
	output logic [CountW-1:0] res_count,
	output logic [StatW-1:0]  res_status,
	output logic              res_load
);
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned NW = $clog2(CAPACITY + 1);
	localparam int unsigned CW = (PosW + 1 > NW) ? PosW + 1 : NW;
	localparam logic [NW-1:0] CapN = NW'(CAPACITY);

	// node pool memories: one access a cycle each
	logic [DATA_WIDTH-1:0] elem_mem [CAPACITY];
	logic [AW-1:0]         next_mem [CAPACITY];
	logic [AW-1:0]         prev_mem [CAPACITY];
	logic                  free_mem [CAPACITY];

	logic [CmdW-1:0]   cmd_q;
	logic [PosW-1:0]   pos_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [AW-1:0]     head_q;
	logic [NW-1:0]     count_q;
	logic [NW-1:0]     idx_q, steps_q;
	logic [AW-1:0]     cur_q, new_q, pred_q, succ_q, alloc_q;
	logic [NW-1:0]     scan_q;
	logic [2:0]        seq_q;
	logic              alloc_v_q; // free_rd_q holds the flag of slot alloc_q
	logic              free_rd_q;
	logic [ValueW-1:0] rd_q;
	logic [StatW-1:0]  stat_q;

	// decode target index from latched command, position and count
	logic [NW-1:0]  idx_d;
	logic [PosW:0]  pm1;
	always_comb begin
		pm1 = (pos_q == '0) ? '0 : {1'b0, pos_q} - 1'b1;
		case (cmd_q) inside
			CMD_PUSH_FRONT, CMD_POP_FRONT: idx_d = '0;
			CMD_PUSH_BACK:  idx_d = count_q;
			CMD_POP_BACK:   idx_d = count_q - 1'b1;
			CMD_PUSH_MID:   idx_d = NW'(({1'b0, count_q} + 1'b1) >> 1);
			CMD_POP_MID:    idx_d = count_q >> 1;
			CMD_INSERT:     idx_d = (CW'(pm1) > CW'(count_q)) ? count_q : NW'(pm1);
			CMD_ERASE:      idx_d = (CW'(pm1) > CW'(count_q - 1'b1))
				? count_q - 1'b1 : NW'(pm1);
			CMD_READ:       idx_d = NW'(pos_q);
			default:        idx_d = '0;
		endcase
	end

	wire is_push = (cmd_q == CMD_PUSH_FRONT || cmd_q == CMD_PUSH_BACK ||
		cmd_q == CMD_PUSH_MID || cmd_q == CMD_INSERT);

	always_comb begin
		st.cmd        = cmd_q;
		st.empty      = (count_q == '0);
		st.full       = (count_q >= CapN);
		st.short_list = (count_q < NW'(2));
		st.range_err  = (CW'(pos_q) >= CW'(count_q));
		st.alloc_hit  = alloc_v_q && free_rd_q;
		st.walk_done  = (steps_q == '0);
		st.seq_done   = (seq_q == 3'd4);
		st.rev_done   = (steps_q == NW'(1)) && seq_q[0];
		st.clr_done   = (scan_q == CapN - 1'b1);
	end

	// walk target: pushes at the end use head as successor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			count_q   <= '0;
			alloc_v_q <= 1'b0;
			seq_q     <= '0;
			scan_q    <= '0;
			steps_q   <= '0;
		end else begin
			if (cm.latch) begin
				seq_q <= '0;
			end
			if (cm.alloc_init) begin
				scan_q    <= '0;
				alloc_v_q <= 1'b0;
			end
			if (cm.alloc_step) begin
				alloc_q   <= scan_q[AW-1:0];
				alloc_v_q <= 1'b1;
				scan_q    <= scan_q + 1'b1;
			end
			if (cm.walk_init) begin
				idx_q   <= idx_d;
				steps_q <= (is_push && idx_d >= count_q) ? '0 : idx_d;
				cur_q   <= head_q;
			end
			if (cm.walk_step) begin
				cur_q   <= next_mem[cur_q];
				steps_q <= steps_q - 1'b1;
			end
			if (cm.link) begin
				seq_q <= seq_q + 1'b1;
				unique case (seq_q)
					3'd0: begin
						new_q  <= alloc_q;
						succ_q <= cur_q;
						pred_q <= prev_mem[cur_q];
					end
					3'd3: begin
						if (count_q == '0 || idx_q == '0) head_q <= new_q;
						count_q <= count_q + 1'b1;
					end
					default: ;
				endcase
			end
			if (cm.unlink) begin
				seq_q <= seq_q + 1'b1;
				unique case (seq_q)
					3'd0: begin
						succ_q <= next_mem[cur_q];
						pred_q <= prev_mem[cur_q];
					end
					3'd3: begin
						if (count_q == NW'(1)) head_q <= '0;
						else if (idx_q == '0) head_q <= succ_q;
						count_q <= count_q - 1'b1;
					end
					default: ;
				endcase
			end
			if (cm.read) seq_q <= 3'd4;
			if (cm.rev_init) begin
				cur_q   <= head_q;
				new_q   <= prev_mem[head_q];
				steps_q <= count_q;
				seq_q   <= '0;
			end
			if (cm.rev_step) begin
				seq_q <= seq_q ^ 3'd1;
				if (seq_q[0]) begin
					cur_q   <= succ_q;
					steps_q <= steps_q - 1'b1;
					if (steps_q == NW'(1)) head_q <= new_q;
				end else begin
					succ_q <= next_mem[cur_q];
					pred_q <= prev_mem[cur_q];
				end
			end
			if (cm.clr_init) begin
				scan_q  <= '0;
				head_q  <= '0;
				count_q <= '0;
			end
			if (cm.clr_step) scan_q <= scan_q + 1'b1;
		end
	end

	// memory writes, one port per array
	always_ff @(posedge clk) begin
		if (cm.alloc_step) free_rd_q <= free_mem[scan_q[AW-1:0]];
		if (cm.link) begin
			unique case (seq_q)
				3'd1: begin
					elem_mem[new_q] <= val_q;
					next_mem[new_q] <= (count_q == '0) ? new_q : succ_q;
					prev_mem[new_q] <= (count_q == '0) ? new_q : pred_q;
					free_mem[new_q] <= 1'b0;
				end
				3'd2: if (count_q != '0) next_mem[pred_q] <= new_q;
				3'd3: if (count_q != '0) prev_mem[succ_q] <= new_q;
				default: ;
			endcase
		end
		if (cm.unlink) begin
			unique case (seq_q)
				3'd1: if (count_q != NW'(1)) next_mem[pred_q] <= succ_q;
				3'd2: if (count_q != NW'(1)) prev_mem[succ_q] <= pred_q;
				3'd3: free_mem[cur_q] <= 1'b1;
				default: ;
			endcase
		end
		if (cm.rev_step && seq_q[0]) begin
			next_mem[cur_q] <= pred_q;
			prev_mem[cur_q] <= succ_q;
		end
		if (cm.clr_step) free_mem[scan_q[AW-1:0]] <= 1'b1;
	end

	// input latch and result
	logic [DATA_WIDTH-1:0] rd_raw;
	always_ff @(posedge clk) begin
		if (cm.latch) begin
			cmd_q  <= in_cmd;
			pos_q  <= in_pos;
			val_q  <= DATA_WIDTH'(in_value);
			rd_q   <= '0;
			stat_q <= ST_OK;
		end
		if (cm.read) rd_q <= ValueW'($signed(elem_mem[cur_q]));
		if (st_code != ST_OK) stat_q <= st_code;
	end
	assign rd_raw = '0;

	assign res_value  = rd_q | ValueW'(rd_raw);
	assign res_count  = CountW'(count_q);
	assign res_status = stat_q;
	assign res_load   = cm.finish;
endmodule

// ===== src/positional_deque_store.sv =====
// Channel | Dir | Word contents
// in      | in  | cmd[4], position[9], value[32]
// out     | out | read_value[32], element_count[9], status[2]
//
// Words are taken one at a time: the input is held off until the result is
// loaded. A rejected, ignored or unknown command goes straight to done; pushes
// search for the lowest free slot and walk links, pops and reads walk links,
// reverse visits every node and clear every slot. The node pool memories take
// one access per cycle. Reset clears head, count and output valid, then a pass
// marks every slot free with the input held off. A waiting output word holds the
// controller in its done state.
`include "assert_macros.svh"
module positional_deque_store import pds_pkg::*; #(
	parameter int unsigned CAPACITY   = CapacityDefault,
	parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
	input logic clk,
	input logic arst_n,
	pds_if.sink   in,
	pds_if.source out
);
	pds_cmd_t  cm;
	pds_stat_t st;
	logic [ValueW-1:0] res_value;
	logic [CountW-1:0] res_count;
	logic [StatW-1:0]  res_status;
	logic              res_load;
	logic              out_v_q;
	logic [ValueW+CountW+StatW-1:0] out_q;

	// controller: sequences each command over the datapath
	pds_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in.valid), .in_ready(in.ready),
		.out_busy(out_v_q && !out.ready),
		.st(st), .cm(cm)
	);

	// datapath: node pool, cursor, head and count
	pds_dp #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_cmd(in.payload[ValueW+PosW+CmdW-1 -: CmdW]),
		.in_pos(in.payload[ValueW+PosW-1 -: PosW]),
		.in_value(in.payload[ValueW-1:0]),
		.cm(cm), .st_code(cm.status), .st(st),
		.res_value(res_value), .res_count(res_count),
		.res_status(res_status), .res_load(res_load)
	);

	// output register: hold word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (res_load) out_v_q <= 1'b1;
		else if (out.ready) out_v_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (res_load) out_q <= {res_value, res_count, res_status};
	end
	assign out.valid   = out_v_q;
	assign out.payload = out_q;

	`ASSERT_NEVER(a_load_over, clk, arst_n, res_load && out_v_q && !out.ready, "result overwritten")
	`ASSERT_CLK(a_in_idle, clk, arst_n, (in.valid && in.ready) |=> !in.ready, "second word taken")
	`ASSERT_NEVER(a_cnt, clk, arst_n, res_count > CountW'(CAPACITY), "count above capacity")
endmodule
